>>> sv/sfr_pkg.sv
// package for the fresnel reflectance unit: widths, stage word and constants
package sfr_pkg;

  localparam int VecFracBitsDef = 14;
  localparam int VecW   = 16;
  localparam int IdxW   = 16;
  localparam int OutW   = 16;
  localparam int Q15One = 32768;

  // division stages: the ratio takes 16 quotient bits, the cos_t^2 quotient takes 32
  localparam int RatDivBits = 16;
  localparam int QDivBits   = 32;
  // one root bit per cell, two radicand bits each: 16 cells cover the 32-bit quotient
  localparam int SqrtBits   = 16;

  // word handed from one cell to the next
  typedef struct packed {
    logic        vld;
    logic        tir;
    logic        n1_gt;
    logic [16:0] c;
    // cos_t^2 division
    logic [61:0] q_rem;
    logic [31:0] q_quo;
    logic [31:0] q_den;
    logic [61:0] q_num;
    // ratio division
    logic [31:0] r_rem;
    logic [15:0] r_quo;
    logic [16:0] r_den;
    logic [31:0] r_num;
    // square root
    logic [33:0] s_rem;
    logic [16:0] s_root;
    logic [31:0] s_val;
  } sfr_word_t;

endpackage

>>> sv/sfr_div_cell.sv
// one cell of the chain: a restoring division step for both quotients
module sfr_div_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  sfr_pkg::sfr_word_t w_in,
  input  logic             do_q,
  input  logic             do_r,
  output sfr_pkg::sfr_word_t w_out
);
  import sfr_pkg::*;

  sfr_word_t w_nxt, w_r;
  logic [62:0] qt;
  logic [32:0] rt;

  always_comb begin
    w_nxt = w_in;
    qt = '0;
    rt = '0;
    if (do_q) begin
      qt = {w_in.q_rem, w_in.q_num[61]};
      w_nxt.q_num = {w_in.q_num[60:0], 1'b0};
      if (qt >= {31'd0, w_in.q_den}) begin
        qt = qt - {31'd0, w_in.q_den};
        w_nxt.q_quo = {w_in.q_quo[30:0], 1'b1};
      end else begin
        w_nxt.q_quo = {w_in.q_quo[30:0], 1'b0};
      end
      w_nxt.q_rem = qt[61:0];
    end
    if (do_r) begin
      rt = {w_in.r_rem, w_in.r_num[31]};
      w_nxt.r_num = {w_in.r_num[30:0], 1'b0};
      if (rt >= {16'd0, w_in.r_den}) begin
        rt = rt - {16'd0, w_in.r_den};
        w_nxt.r_quo = {w_in.r_quo[14:0], 1'b1};
      end else begin
        w_nxt.r_quo = {w_in.r_quo[14:0], 1'b0};
      end
      w_nxt.r_rem = rt[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r.vld <= 1'b0;
    end else begin
      w_r.vld <= w_nxt.vld;
    end
    w_r.tir   <= w_nxt.tir;
    w_r.n1_gt <= w_nxt.n1_gt;
    w_r.c     <= w_nxt.c;
    w_r.q_rem <= w_nxt.q_rem;
    w_r.q_quo <= w_nxt.q_quo;
    w_r.q_den <= w_nxt.q_den;
    w_r.q_num <= w_nxt.q_num;
    w_r.r_rem <= w_nxt.r_rem;
    w_r.r_quo <= w_nxt.r_quo;
    w_r.r_den <= w_nxt.r_den;
    w_r.r_num <= w_nxt.r_num;
    w_r.s_rem <= w_nxt.s_rem;
    w_r.s_root <= w_nxt.s_root;
    w_r.s_val <= w_nxt.s_val;
  end

  assign w_out = w_r;
endmodule

>>> sv/sfr_sqrt_cell.sv
// one cell of the chain: one result bit of the integer square root
module sfr_sqrt_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  sfr_pkg::sfr_word_t w_in,
  output sfr_pkg::sfr_word_t w_out
);
  import sfr_pkg::*;

  sfr_word_t w_nxt, w_r;
  logic [35:0] t;
  logic [35:0] trial;

  always_comb begin
    w_nxt = w_in;
    // bring down two bits of the radicand
    t = {w_in.s_rem, w_in.s_val[31:30]};
    trial = {17'd0, w_in.s_root, 2'b01};
    w_nxt.s_val = {w_in.s_val[29:0], 2'b00};
    if (t >= trial) begin
      w_nxt.s_rem = 34'(t - trial);
      w_nxt.s_root = {w_in.s_root[15:0], 1'b1};
    end else begin
      w_nxt.s_rem = t[33:0];
      w_nxt.s_root = {w_in.s_root[15:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r.vld <= 1'b0;
    end else begin
      w_r.vld <= w_nxt.vld;
    end
    w_r.tir   <= w_nxt.tir;
    w_r.n1_gt <= w_nxt.n1_gt;
    w_r.c     <= w_nxt.c;
    w_r.q_rem <= w_nxt.q_rem;
    w_r.q_quo <= w_nxt.q_quo;
    w_r.q_den <= w_nxt.q_den;
    w_r.q_num <= w_nxt.q_num;
    w_r.r_rem <= w_nxt.r_rem;
    w_r.r_quo <= w_nxt.r_quo;
    w_r.r_den <= w_nxt.r_den;
    w_r.r_num <= w_nxt.r_num;
    w_r.s_rem <= w_nxt.s_rem;
    w_r.s_root <= w_nxt.s_root;
    w_r.s_val <= w_nxt.s_val;
  end

  assign w_out = w_r;
endmodule

>>> sv/schlick_fresnel_reflectance_unit.sv
// schlick fresnel reflectance unit: front end, cell chain and power tail
//
//  port group   dir  handshake        content
//  in_*         in   start & !busy    eye, normal, both indices
//  out_*        out  out_valid pulse  reflectance q1.15, tir flag
//
// one word per cycle; each word passes front end stages a to d, the 32 division cells
// and 16 square root cells of the chain, then the power tail.
// busy is always low; the chain never stops, results appear in order.
// reset (rst_n low, synchronous) clears all valid bits; words in flight are dropped.
// the receiver cannot stall: out_valid lasts one cycle per word.
module schlick_fresnel_reflectance_unit #(
  parameter int VEC_FRAC_BITS = sfr_pkg::VecFracBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic signed [15:0] in_eye_x,
  input  logic signed [15:0] in_eye_y,
  input  logic signed [15:0] in_eye_z,
  input  logic signed [15:0] in_normal_x,
  input  logic signed [15:0] in_normal_y,
  input  logic signed [15:0] in_normal_z,
  input  logic [15:0] in_index_from,
  input  logic [15:0] in_index_to,
  output logic        out_valid,
  output logic [15:0] out_reflectance,
  output logic        out_total_internal
);
  import sfr_pkg::*;

  localparam int Shift = 2 * VEC_FRAC_BITS - 15;
  localparam int NCell = QDivBits + SqrtBits;

  assign busy = 1'b0;

  // stage a: products
  logic        a_vld_r;
  logic signed [31:0] px_r, py_r, pz_r;
  logic [15:0] a_n1_r, a_n2_r;
  // stage b: dot product, squares
  logic        b_vld_r;
  logic signed [33:0] dot_r;
  logic [15:0] b_n1_r, b_n2_r;
  logic [31:0] n1sq_r, n2sq_r;
  // stage c: cosine and 1 - c^2
  logic        c_vld_r;
  logic [16:0] c_c_r;
  logic [31:0] c_n1sq_r, c_n2sq_r;
  logic [30:0] omc2_r;
  logic [15:0] c_n1_r, c_n2_r;
  // stage d: lhs product
  logic        d_vld_r;
  logic [61:0] lhs_r;
  logic [16:0] d_c_r;
  logic [31:0] d_n2sq_r;
  logic [15:0] d_n1_r, d_n2_r;

  logic [16:0] c_nxt;
  logic [33:0] dpos;

  always_comb begin
    dpos = 34'(dot_r >>> Shift);
    if (dot_r <= 0) c_nxt = '0;
    else if (dpos > 34'(Q15One)) c_nxt = 17'(Q15One);
    else c_nxt = dpos[16:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else begin
      a_vld_r <= start;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
    end
    px_r <= in_eye_x * in_normal_x;
    py_r <= in_eye_y * in_normal_y;
    pz_r <= in_eye_z * in_normal_z;
    a_n1_r <= in_index_from;
    a_n2_r <= in_index_to;
    dot_r <= 34'(px_r) + 34'(py_r) + 34'(pz_r);
    n1sq_r <= a_n1_r * a_n1_r;
    n2sq_r <= a_n2_r * a_n2_r;
    b_n1_r <= a_n1_r;
    b_n2_r <= a_n2_r;
    c_c_r <= c_nxt;
    omc2_r <= 31'((32'd1 << 30) - 32'(c_nxt) * 32'(c_nxt));
    c_n1sq_r <= n1sq_r;
    c_n2sq_r <= n2sq_r;
    c_n1_r <= b_n1_r;
    c_n2_r <= b_n2_r;
    // 32 x 31 product, single multiplier
    lhs_r <= 62'(c_n1sq_r) * 62'(omc2_r);
    d_c_r <= c_c_r;
    d_n2sq_r <= c_n2sq_r;
    d_n1_r <= c_n1_r;
    d_n2_r <= c_n2_r;
  end

  // chain head
  sfr_word_t head;
  logic [61:0] rhs;
  logic        gt;
  always_comb begin
    rhs = {d_n2sq_r, 30'd0};
    gt = d_n1_r > d_n2_r;
    head = '0;
    head.vld = d_vld_r;
    head.n1_gt = gt;
    head.tir = gt && (lhs_r > rhs);
    head.c = d_c_r;
    head.q_num = rhs - lhs_r;
    head.q_den = d_n2sq_r;
    head.r_num = {15'd0, (gt ? d_n1_r - d_n2_r : d_n2_r - d_n1_r), 1'b0} << 14;
    head.r_den = 17'(d_n1_r) + 17'(d_n2_r);
  end

  sfr_word_t chain [NCell+1];
  assign chain[0] = head;

  // the cos_t^2 quotient is below 2^32 whenever no reflection; 62-bit numerator
  // is first shifted so that 32 steps yield floor(num/den)
  for (genvar g = 0; g < QDivBits; g++) begin : g_div
    sfr_word_t w_fix;
    always_comb begin
      w_fix = chain[g];
      if (g == 0) begin
        // preload the top 30 numerator bits into the remainder
        w_fix.q_rem = {32'd0, chain[g].q_num[61:32]};
        w_fix.q_num = {chain[g].q_num[31:0], 30'd0};
        w_fix.r_rem = '0;
      end
    end
    sfr_div_cell u_cell (
      .clk(clk), .rst_n(rst_n), .w_in(w_fix),
      .do_q(1'b1), .do_r(g < RatDivBits + 16),
      .w_out(chain[g+1])
    );
  end

  for (genvar g = 0; g < SqrtBits; g++) begin : g_sqrt
    sfr_word_t w_fix;
    always_comb begin
      w_fix = chain[QDivBits+g];
      if (g == 0) begin
        w_fix.s_rem = '0;
        w_fix.s_root = '0;
        // zero divisor gives a zero quotient; sqrt of a 32-bit value
        w_fix.s_val = (chain[QDivBits].q_den == 0) ? 32'd0 : chain[QDivBits].q_quo;
      end
    end
    sfr_sqrt_cell u_cell (
      .clk(clk), .rst_n(rst_n), .w_in(w_fix), .w_out(chain[QDivBits+g+1])
    );
  end

  // tail: power and blend
  sfr_word_t t;
  assign t = chain[NCell];
  logic [16:0] cf, x0;
  logic [16:0] rat;
  always_comb begin
    cf = t.c;
    if (t.n1_gt) cf = (t.s_root > 17'(Q15One)) ? 17'(Q15One) : t.s_root;
    x0 = 17'(Q15One) - cf;
    rat = (t.r_den == 0) ? 17'd0 : {1'b0, t.r_quo};
  end

  logic [4:0]  p_vld_r;
  logic [4:0]  p_tir_r;
  logic [16:0] x_r [4];
  logic [16:0] p_r [5];
  logic [16:0] r0_r [5];
  logic [15:0] res_r;
  logic        res_tir_r;
  logic        res_vld_r;
  logic [33:0] r0sq;
  logic [33:0] pm [4];
  logic [33:0] blend;
  logic [17:0] rsum;

  always_comb begin
    r0sq = 34'(rat) * 34'(rat);
    for (int i = 0; i < 4; i++) pm[i] = 34'(p_r[i]) * 34'(x_r[i]);
    blend = 34'(17'(Q15One) - r0_r[4]) * 34'(p_r[4]);
    rsum = 18'(r0_r[4]) + 18'(blend >> 15);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= '0;
      res_vld_r <= 1'b0;
    end else begin
      p_vld_r <= {p_vld_r[3:0], t.vld};
      res_vld_r <= p_vld_r[4];
    end
    p_tir_r <= {p_tir_r[3:0], t.tir};
    x_r[0] <= x0;
    p_r[0] <= x0;
    r0_r[0] <= 17'(r0sq >> 15);
    for (int i = 0; i < 3; i++) x_r[i+1] <= x_r[i];
    for (int i = 0; i < 4; i++) begin
      p_r[i+1] <= 17'(pm[i] >> 15);
      r0_r[i+1] <= r0_r[i];
    end
    res_tir_r <= p_tir_r[4];
    if (p_tir_r[4]) res_r <= 16'(Q15One);
    else if (rsum > 18'(Q15One)) res_r <= 16'(Q15One);
    else res_r <= rsum[15:0];
  end

  assign out_valid = res_vld_r;
  assign out_reflectance = res_r;
  assign out_total_internal = res_tir_r;

  a_tir_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_total_internal |-> out_reflectance == 16'(Q15One))
    else $error("tir result not one");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_reflectance <= 16'(Q15One))
    else $error("reflectance above one");
  a_tir_dir: assert property (@(posedge clk) disable iff (!rst_n)
    head.vld && head.tir |-> head.n1_gt)
    else $error("tir without denser source");
endmodule
